FILE: hdl/pdob_pkg.sv
// ----------------------------------------------------------------------------
// pdob_pkg: shared types and constants of the phase distortion oscillator bank
// Field widths, register indexes, sequencer states, the sine table and the
// wave table lookup used by the oscillator bank.
// ----------------------------------------------------------------------------
package pdob_pkg;

  // Default sizes of the voice store and the echo loop.
  localparam int unsigned MAX_VOICES_DEF = 32;
  localparam int unsigned ECHO_DEPTH_DEF = 16384;

  // Field widths.
  localparam int unsigned PITCH_W    = 15;
  localparam int unsigned DETUNE_W   = 13;
  localparam int unsigned PH_AMT_W   = 13;
  localparam int unsigned ENV_W      = 16;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned PHASE_W    = 16;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned MOD_W      = 17;
  localparam int unsigned CD_W       = 10;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 32;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_VOICES = 3'd0,
    REG_MOD_VOLUME    = 3'd1,
    REG_WAVE_SELECT   = 3'd2,
    REG_ECHO_LENGTH   = 3'd3,
    REG_ECHO_GAIN_MUL = 3'd4,
    REG_ECHO_GAIN_DIV = 3'd5
  } cfg_reg_e;

  // Register reset values.
  localparam logic [5:0]  ACTIVE_VOICES_RST = 6'd24;
  localparam logic [7:0]  MOD_VOLUME_RST    = 8'd64;
  localparam logic [1:0]  WAVE_SELECT_RST   = 2'd0;
  localparam logic [14:0] ECHO_LENGTH_RST   = 15'd16384;
  localparam logic [3:0]  ECHO_GAIN_MUL_RST = 4'd1;
  localparam logic [3:0]  ECHO_GAIN_DIV_RST = 4'd4;

  // Wave codes; every other code selects the sine table.
  localparam logic [1:0] WAVE_SAW    = 2'd1;
  localparam logic [1:0] WAVE_SQUARE = 2'd2;

  // Envelope countdown and modulation limit.
  localparam logic [CD_W-1:0] ENV_RELOAD = 10'd582;
  localparam logic [CD_W-1:0] ENV_RESET  = 10'd549;
  localparam logic signed [MOD_W:0] MOD_CLAMP = 18'sd255;

  // Feedback divider: magnitude width, quotient bits per cycle, cycles.
  localparam int unsigned DIV_W      = 20;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_CYCLES = DIV_W / DIV_STEPS;
  localparam int unsigned DCNT_W     = 3;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VOICE,
    ST_MODMUL,
    ST_MODADD,
    ST_DIV,
    ST_FINISH
  } state_e;

  // One entry of the voice store.
  typedef struct packed {
    logic [PHASE_W-1:0] distort;
    logic [COUNT_W-1:0] count;
    logic [PHASE_W-1:0] phase;
  } voice_t;

  localparam logic [7:0] SINE_ROM [256] = '{
    8'd0,8'd0,8'd0,8'd0,8'd1,8'd1,8'd1,8'd2,8'd2,8'd3,8'd4,8'd5,8'd5,8'd6,8'd7,8'd9,
    8'd10,8'd11,8'd12,8'd14,8'd15,8'd16,8'd18,8'd20,8'd21,8'd23,8'd25,8'd27,8'd29,
    8'd31,8'd33,8'd35,8'd37,8'd39,8'd42,8'd44,8'd46,8'd49,8'd51,8'd54,8'd56,8'd59,
    8'd62,8'd64,8'd67,8'd70,8'd73,8'd76,8'd78,8'd81,8'd84,8'd87,8'd90,8'd93,8'd96,
    8'd99,8'd102,8'd105,8'd108,8'd111,8'd115,8'd118,8'd121,8'd124,
    8'd127,8'd130,8'd133,8'd136,8'd139,8'd143,8'd146,8'd149,8'd152,8'd155,8'd158,
    8'd161,8'd164,8'd167,8'd170,8'd173,8'd176,8'd178,8'd181,8'd184,8'd187,8'd190,
    8'd192,8'd195,8'd198,8'd200,8'd203,8'd205,8'd208,8'd210,8'd212,8'd215,8'd217,
    8'd219,8'd221,8'd223,8'd225,8'd227,8'd229,8'd231,8'd233,8'd234,8'd236,8'd238,
    8'd239,8'd240,
    8'd242,8'd243,8'd244,8'd245,8'd247,8'd248,8'd249,8'd249,8'd250,8'd251,8'd252,
    8'd252,8'd253,8'd253,8'd253,8'd254,8'd254,8'd254,8'd254,8'd254,8'd254,8'd254,
    8'd253,8'd253,8'd253,8'd252,8'd252,8'd251,8'd250,8'd249,8'd249,8'd248,8'd247,
    8'd245,8'd244,8'd243,8'd242,8'd240,8'd239,8'd238,8'd236,8'd234,8'd233,8'd231,
    8'd229,8'd227,8'd225,8'd223,
    8'd221,8'd219,8'd217,8'd215,8'd212,8'd210,8'd208,8'd205,8'd203,8'd200,8'd198,
    8'd195,8'd192,8'd190,8'd187,8'd184,8'd181,8'd178,8'd176,8'd173,8'd170,8'd167,
    8'd164,8'd161,8'd158,8'd155,8'd152,8'd149,8'd146,8'd143,8'd139,8'd136,8'd133,
    8'd130,8'd127,8'd124,8'd121,8'd118,8'd115,8'd111,8'd108,8'd105,8'd102,8'd99,
    8'd96,8'd93,8'd90,8'd87,8'd84,8'd81,8'd78,
    8'd76,8'd73,8'd70,8'd67,8'd64,8'd62,8'd59,8'd56,8'd54,8'd51,8'd49,8'd46,8'd44,
    8'd42,8'd39,8'd37,8'd35,8'd33,8'd31,8'd29,8'd27,8'd25,8'd23,8'd21,8'd20,8'd18,
    8'd16,8'd15,8'd14,8'd12,8'd11,8'd10,8'd9,8'd7,8'd6,8'd5,8'd5,8'd4,8'd3,8'd2,
    8'd2,8'd1,8'd1,8'd1,8'd0,8'd0,8'd0
  };

  // Wave table lookup for the selected wave shape.
  function automatic logic [7:0] wave_lookup(input logic [1:0] sel, input logic [7:0] idx);
    logic [7:0] val;
    case (sel)
      WAVE_SAW:    val = idx;
      WAVE_SQUARE: val = idx[7] ? 8'd255 : 8'd0;
      default:     val = SINE_ROM[idx];
    endcase
    return val;
  endfunction

endpackage

FILE: hdl/phase_distortion_oscillator_bank_top.sv
// ----------------------------------------------------------------------------
// phase_distortion_oscillator_bank_top: phase distortion voices with echo
// A small sequencer walks the voice store one voice per cycle through a
// shared voice update unit, then updates the modulation, mixes the echo
// loop and, for a nonzero denominator, computes the echo feedback with an iterative divider.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload (lowest bit first)
//  s_axis    in         pitch_step, detune_step, phase_amount, envelope_amount
//  m_axis    out        left_sample, right_sample
//  cfg       in         register index, write data
//
//  After its accepting cycle a sample passes through the voice update unit, one
//  voice a cycle for N voices, where N is the active voice count clipped to
//  MAX_VOICES, then through the modulation multiply and add, the feedback
//  divider (four quotient bits a cycle) and the final state. With a zero
//  feedback denominator the divider is skipped. After reset the echo store is
//  cleared one entry a cycle while no sample is accepted; configuration
//  writes are taken throughout.
//  A new sample is accepted while a result waits in the output register; the
//  sequencer holds in its final state until that register is free.
//
module phase_distortion_oscillator_bank_top
  import pdob_pkg::*;
#(
  parameter int unsigned MAX_VOICES = MAX_VOICES_DEF,
  parameter int unsigned ECHO_DEPTH = ECHO_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Sample input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: pitch_step[14:0], detune_step[27:15], phase_amount[40:28],
  //        envelope_amount[56:41], zero fill [63:57]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Result output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: left_sample[15:0], right_sample[31:16]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned VADDR_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int unsigned NV_RAW_W = $clog2(MAX_VOICES + 1);
  localparam int unsigned NV_W = (NV_RAW_W > 6) ? NV_RAW_W : 6;
  localparam int unsigned EADDR_W = $clog2(ECHO_DEPTH);
  localparam int unsigned LEN_RAW_W = $clog2(ECHO_DEPTH + 1);
  localparam int unsigned LEN_W = ((LEN_RAW_W > 15) ? LEN_RAW_W : 15) + 1;
  localparam logic [NV_W-1:0] NV_MAX = NV_W'(MAX_VOICES);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(ECHO_DEPTH);
  localparam logic [EADDR_W-1:0] CLR_LAST = EADDR_W'(ECHO_DEPTH - 1);

  // Configuration registers.
  logic [5:0]  active_q;
  logic [7:0]  mod_vol_q;
  logic [1:0]  wave_sel_q;
  logic [14:0] echo_len_q;
  logic [3:0]  gain_mul_q;
  logic [3:0]  gain_div_q;

  // Control state.
  state_e              state_q, state_d;
  logic [EADDR_W-1:0]  clr_q;
  logic [NV_W-1:0]     vidx_q;
  logic [DCNT_W-1:0]   dcnt_q;
  logic                first_q;
  logic                m_valid_q;
  logic [MAX_VOICES-1:0] vvalid_q;
  logic                vrd_valid_q;
  logic [EADDR_W-1:0]  wi_q;
  logic [EADDR_W-1:0]  ri_q;
  logic [CD_W-1:0]     cd_q;
  logic signed [MOD_W-1:0] mod_q;

  // Payload registers.
  logic [PHASE_W-1:0]          incr_q;
  logic signed [DETUNE_W-1:0]  detune_q;
  logic signed [PH_AMT_W-1:0]  ph_amt_q;
  logic signed [ENV_W-1:0]     env_q;
  logic [SAMPLE_W-1:0]         sum0_q, sum1_q;
  logic [SAMPLE_W-1:0]         left_echo_q;
  logic [SAMPLE_W-1:0]         left_q, right_q;
  logic signed [24:0]          prod_q;
  logic [DIV_W-1:0]            dquo_q;
  logic [4:0]                  drem_q;
  logic                        dneg_q;
  logic [SAMPLE_W-1:0]         fb_q;
  logic [OUT_DATA_W-1:0]       m_data_q;
  voice_t                      vrd_q;
  logic [SAMPLE_W-1:0]         erd_q;

  // Memories.
  voice_t              vmem [MAX_VOICES];
  logic [SAMPLE_W-1:0] emem [ECHO_DEPTH];

  // Handshake helpers.
  logic in_fire, out_free, last_voice;
  logic [NV_W-1:0] nv;

  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign out_free    = !m_valid_q || m_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign nv          = (NV_W'(active_q) > NV_MAX) ? NV_MAX : NV_W'(active_q);
  assign last_voice  = (vidx_q == nv - NV_W'(1));

  // Echo index stepping for the next sample.
  logic [LEN_W-1:0]   echo_len, wi_inc, ri_inc;
  logic [EADDR_W-1:0] wi_n, ri_n;

  always_comb begin
    echo_len = (LEN_W'(echo_len_q) > LEN_MAX) ? LEN_MAX : LEN_W'(echo_len_q);
    wi_inc   = LEN_W'(wi_q) + LEN_W'(1);
    wi_n     = (wi_inc >= echo_len) ? '0 : wi_inc[EADDR_W-1:0];
    ri_inc   = LEN_W'(wi_n) + LEN_W'(1);
    ri_n     = (ri_inc >= echo_len) ? '0 : ri_inc[EADDR_W-1:0];
  end

  // Shared voice update unit: phase step, wrap handling, two wave lookups.
  voice_t             cur, vnew;
  logic [PHASE_W-1:0] ph_sum, dist_a;
  logic               wrap;
  logic [7:0]         widx, widx2;
  logic [8:0]         wsum;

  always_comb begin
    cur          = vrd_valid_q ? vrd_q : '0;
    ph_sum       = cur.phase + incr_q;
    wrap         = ph_sum[PHASE_W-1];
    vnew.phase   = {1'b0, ph_sum[PHASE_W-2:0]};
    vnew.count   = wrap ? cur.count + 8'd2 : cur.count;
    dist_a       = wrap ? cur.distort + mod_q[PHASE_W-1:0] : cur.distort;
    vnew.distort = (vnew.count == '0) ? '0 : dist_a;
    widx         = vnew.distort[10:3];
    widx2        = widx + vnew.count + 8'd128;
    wsum         = {1'b0, wave_lookup(wave_sel_q, widx)} +
                   {1'b0, wave_lookup(wave_sel_q, widx2)};
  end

  // Voice store read address: the next voice while walking, else voice zero.
  logic [VADDR_W-1:0] vrd_addr, vwr_addr;

  assign vwr_addr = vidx_q[VADDR_W-1:0];
  assign vrd_addr = (state_q == ST_VOICE && !last_voice) ?
                    vidx_q[VADDR_W-1:0] + VADDR_W'(1) : '0;

  // Modulation update and echo mixing.
  logic signed [MOD_W:0]  mod_sum;
  logic signed [MOD_W-1:0] mod_n;
  logic [SAMPLE_W-1:0]    right_n;
  logic signed [20:0]     fb_prod;
  logic [20:0]            fb_mag;

  always_comb begin
    mod_sum = 18'(prod_q >>> 8) + 18'(ph_amt_q);
    mod_n   = (mod_sum > MOD_CLAMP) ? MOD_CLAMP[MOD_W-1:0] : mod_sum[MOD_W-1:0];
    right_n = sum1_q + erd_q;
    fb_prod = $signed(right_n) * $signed({1'b0, gain_mul_q});
    fb_mag  = fb_prod[20] ? (~fb_prod + 21'sd1) : fb_prod;
  end

  // Restoring divider, several quotient bits per cycle.
  logic [DIV_W-1:0] div_quo;
  logic [4:0]       div_rem;

  always_comb begin
    div_quo = dquo_q;
    div_rem = drem_q;
    for (int k = 0; k < DIV_STEPS; k++) begin
      div_rem = {div_rem[3:0], div_quo[DIV_W-1]};
      div_quo = {div_quo[DIV_W-2:0], 1'b0};
      if (div_rem >= {1'b0, gain_div_q}) begin
        div_rem    = div_rem - {1'b0, gain_div_q};
        div_quo[0] = 1'b1;
      end
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = (nv == '0) ? ST_MODMUL : ST_VOICE;
      end
      ST_VOICE: begin
        if (last_voice) state_d = ST_MODMUL;
      end
      ST_MODMUL: begin
        state_d = ST_MODADD;
      end
      ST_MODADD: begin
        state_d = (gain_div_q == '0) ? ST_FINISH : ST_DIV;
      end
      ST_DIV: begin
        if (dcnt_q == DCNT_W'(1)) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= ACTIVE_VOICES_RST;
      mod_vol_q  <= MOD_VOLUME_RST;
      wave_sel_q <= WAVE_SELECT_RST;
      echo_len_q <= ECHO_LENGTH_RST;
      gain_mul_q <= ECHO_GAIN_MUL_RST;
      gain_div_q <= ECHO_GAIN_DIV_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ACTIVE_VOICES: active_q   <= cfg_data_i[5:0];
        REG_MOD_VOLUME:    mod_vol_q  <= cfg_data_i[7:0];
        REG_WAVE_SELECT:   wave_sel_q <= cfg_data_i[1:0];
        REG_ECHO_LENGTH:   echo_len_q <= cfg_data_i;
        REG_ECHO_GAIN_MUL: gain_mul_q <= cfg_data_i[3:0];
        REG_ECHO_GAIN_DIV: gain_div_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Sequencer counters, block state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      vidx_q    <= '0;
      dcnt_q    <= '0;
      first_q   <= 1'b0;
      m_valid_q <= 1'b0;
      vvalid_q  <= '0;
      wi_q      <= '0;
      ri_q      <= '0;
      cd_q      <= ENV_RESET;
      mod_q     <= '0;
    end else begin
      first_q <= in_fire;
      if (state_q == ST_FINISH && out_free) m_valid_q <= 1'b1;
      else if (m_axis_tready)               m_valid_q <= 1'b0;
      if (state_q == ST_CLEAR) clr_q <= clr_q + EADDR_W'(1);
      if (in_fire) begin
        vidx_q <= '0;
        wi_q   <= wi_n;
        ri_q   <= ri_n;
      end
      if (state_q == ST_VOICE) begin
        vvalid_q[vwr_addr] <= 1'b1;
        vidx_q             <= vidx_q + NV_W'(1);
      end
      if (state_q == ST_MODADD) begin
        dcnt_q <= (gain_div_q == '0) ? '0 : DCNT_W'(DIV_CYCLES);
        if (cd_q == '0) begin
          cd_q  <= ENV_RELOAD;
          mod_q <= mod_n;
        end else begin
          cd_q <= cd_q - CD_W'(1);
        end
      end
      if (state_q == ST_DIV) dcnt_q <= dcnt_q - DCNT_W'(1);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      incr_q   <= PHASE_W'(s_axis_tdata[PITCH_W-1:0]);
      detune_q <= $signed(s_axis_tdata[27:15]);
      ph_amt_q <= $signed(s_axis_tdata[40:28]);
      env_q    <= $signed(s_axis_tdata[56:41]);
      sum0_q   <= '0;
      sum1_q   <= '0;
    end
    if (first_q) left_echo_q <= erd_q;
    if (state_q == ST_VOICE) begin
      incr_q <= incr_q + PHASE_W'(detune_q);
      if (vidx_q[0]) sum1_q <= sum1_q + SAMPLE_W'(wsum);
      else           sum0_q <= sum0_q + SAMPLE_W'(wsum);
    end
    if (state_q == ST_MODMUL) prod_q <= $signed({1'b0, mod_vol_q}) * env_q;
    if (state_q == ST_MODADD) begin
      left_q  <= sum0_q + left_echo_q;
      right_q <= right_n;
      dquo_q  <= fb_mag[DIV_W-1:0];
      drem_q  <= '0;
      dneg_q  <= fb_prod[20];
      fb_q    <= '0;
    end
    if (state_q == ST_DIV) begin
      dquo_q <= div_quo;
      drem_q <= div_rem;
      if (dcnt_q == DCNT_W'(1)) begin
        fb_q <= dneg_q ? SAMPLE_W'(~div_quo + DIV_W'(1)) : div_quo[SAMPLE_W-1:0];
      end
    end
    if (state_q == ST_FINISH && out_free) m_data_q <= {right_q, left_q};
  end

  // Voice store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_VOICE) vmem[vwr_addr] <= vnew;
    vrd_q <= vmem[vrd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vrd_valid_q <= 1'b0;
    end else begin
      vrd_valid_q <= vvalid_q[vrd_addr];
    end
  end

  // Echo store: clearing sweep or feedback write, registered read at ri_q.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      emem[clr_q] <= '0;
    end else if (state_q == ST_FINISH && out_free) begin
      emem[wi_q] <= fb_q;
    end
    erd_q <= emem[ri_q];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Assertions.
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != ST_IDLE))
    else $error("sequencer stayed idle after accepting a sample");

  a_echo_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(wi_q) < ECHO_DEPTH) && (int'(ri_q) < ECHO_DEPTH))
    else $error("echo index beyond the echo store");

  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !m_valid_q)
    else $error("result presented during the clearing sweep");

  a_divider_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |-> (dcnt_q == '0))
    else $error("result finished before the divider completed");

endmodule
